// ===== hw/rtl/jaa_pkg.sv =====
// Package for the jet angularity accumulator: field widths, sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package jaa_pkg;
   localparam int PT_W = 16;
   localparam int RES_W = 16;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SQ     = 10'b0000000010,
      ST_ROOT1  = 10'b0000000100,
      ST_THETA  = 10'b0000001000,
      ST_ROOT2  = 10'b0000010000,
      ST_ACC1   = 10'b0000100000,
      ST_ACC2   = 10'b0001000000,
      ST_DIVSET = 10'b0010000000,
      ST_DIV    = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;
endpackage

// ===== hw/rtl/jaa_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the final normalizations.
// No dependencies; the top level sets the numerator and denominator widths.
`timescale 1ns / 1ps
module jaa_divider #(
   parameter int NUM_W = 72,
   parameter int DEN_W = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign busy = (cnt_ff != '0) || start;
   assign quot = quot_ff;
endmodule

// ===== hw/rtl/jet_angularity_accumulator_top.sv =====
// Top level of the jet angularity accumulator: sequencer, shared square root, accumulators.
// Depends on jaa_pkg and jaa_divider.
`timescale 1ns / 1ps
// One request carries one jet constituent; the request that has tlast set closes the jet and
// produces one response with multiplicity, pTD, LHA, width and thrust. A counted constituent
// keeps the block busy after it is accepted, so no new request is taken until it is done: one
// shared bit-pair square root runs twice (for deltaR and for root theta, 24 steps each), with
// theta and then pt squared between them and the two accumulation multiplies after them. A
// request that adds nothing (empty, or beyond the constituent limit) skips the square root, and
// unless it closes the jet the block stays ready. A closing request adds four serial divisions
// on one shared restoring divider, unless the pt sum is zero, and then loads the response. A
// response waits in its output register until taken; meanwhile further constituents are
// accepted and accumulated, and only the closing of the next jet waits for the response.
module jet_angularity_accumulator_top #(
   parameter int MAX_CONSTITUENTS = 255,
   parameter int ANGLE_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: constituent_pt[15:0], constituent_eta[31:16], constituent_phi[46:32],
   // axis_eta[62:47], axis_phi[77:63], zero fill [79:78]
   input  logic [79:0] req_tdata,
   input  logic        req_tlast,
   // tuser: no_constituent
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: multiplicity[7:0], ptd_value[23:8], lha_value[39:24], width_value[55:40],
   // thrust_value[71:56]
   output logic [71:0] rsp_tdata,
   // tuser: zero_momentum
   output logic        rsp_tuser
);
   import jaa_pkg::*;

   // pi in the angle format, rounded from a Q30 constant.
   localparam longint PI_Q30 = 64'd3373259426;
   localparam logic [17:0] PI_Q =
      18'((PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));
   localparam int DIV_NW = 72;
   localparam int DIV_DW = 60;

   state_type state_ff, state_in;
   logic [15:0] inv_radius_ff;
   logic [7:0]  count_ff;
   logic [23:0] sum_pt_ff;
   logic [39:0] sum_pt2_ff;
   logic [39:0] sum_root_ff;
   logic [43:0] sum_ang_ff;
   logic [55:0] sum_ang2_ff;
   logic [15:0] pt_ff;
   logic        last_ff;
   // Shared square root unit state.
   logic [47:0] sq_x_ff, sq_x_in;
   logic [47:0] sq_res_ff, sq_res_in;
   logic [47:0] sq_bit_ff, sq_bit_in;
   logic [15:0] theta_ff;
   logic [2:0]  div_idx_ff;
   logic [15:0] r_ptd_ff, r_lha_ff, r_wid_ff, r_thr_ff;
   logic [7:0]  r_mult_ff;
   logic        r_zero_ff;
   logic        rsp_valid_ff;

   // Input field views.
   logic signed [15:0] c_eta, a_eta;
   logic signed [14:0] c_phi, a_phi;
   logic signed [17:0] deta, dphi_raw, dphi_w;
   logic [17:0] ae, ap;
   assign c_eta = req_tdata[31:16];
   assign c_phi = req_tdata[46:32];
   assign a_eta = req_tdata[62:47];
   assign a_phi = req_tdata[77:63];

   always_comb begin
      deta = 18'(c_eta) - 18'(a_eta);
      dphi_raw = 18'(c_phi) - 18'(a_phi);
      // Range of the difference is within two turns; at most one wrap is needed.
      dphi_w = dphi_raw;
      if (dphi_raw >= $signed(PI_Q)) dphi_w = dphi_raw - $signed(PI_Q << 1);
      else if (dphi_raw < -$signed(PI_Q)) dphi_w = dphi_raw + $signed(PI_Q << 1);
      ae = deta[17] ? 18'(-deta) : 18'(deta);
      ap = dphi_w[17] ? 18'(-dphi_w) : 18'(dphi_w);
   end

   logic accepted;
   assign req_tready = (state_ff == ST_IDLE);
   assign accepted = req_tvalid && req_tready;
   logic take;
   assign take = !req_tuser && (count_ff < 8'(MAX_CONSTITUENTS));

   // Square root step.
   logic [47:0] sq_sum;
   logic        sq_ge;
   assign sq_sum = sq_res_ff + sq_bit_ff;
   assign sq_ge = sq_x_ff >= sq_sum;

   // Shared multiplier (one product per cycle, registered).
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] prod_ff;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // Divider.
   logic              div_start, div_busy;
   logic [DIV_NW-1:0] div_num, div_quot;
   logic [DIV_DW-1:0] div_den;
   jaa_divider #(.NUM_W(DIV_NW), .DEN_W(DIV_DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num),
      .denom(div_den), .busy(div_busy), .quot(div_quot)
   );

   logic [15:0] q_sat;
   assign q_sat = (div_quot > DIV_NW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];

   logic [47:0] s_sq;
   assign s_sq = 48'(sum_pt_ff) * 48'(sum_pt_ff);

   always_comb begin
      div_num = '0;
      div_den = '0;
      case (div_idx_ff)
         3'd0: begin
            div_num = DIV_NW'({sum_pt2_ff, 16'h0});
            div_den = DIV_DW'(s_sq);
         end
         3'd1: begin
            div_num = DIV_NW'(sum_root_ff);
            div_den = DIV_DW'(sum_pt_ff);
         end
         3'd2: begin
            div_num = DIV_NW'(sum_ang_ff);
            div_den = DIV_DW'(sum_pt_ff);
         end
         default: begin
            div_num = DIV_NW'(sum_ang2_ff);
            div_den = DIV_DW'(sum_pt_ff) << ANGLE_FRAC_BITS;
         end
      endcase
   end

   // Sequencer.
   logic [47:0] root_out;
   assign root_out = sq_ge ? ((sq_res_ff >> 1) + sq_bit_ff) : (sq_res_ff >> 1);

   always_comb begin
      state_in = state_ff;
      sq_x_in = sq_x_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      div_start = 1'b0;
      mul_a = 32'(pt_ff);
      mul_b = 32'(pt_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               if (take) begin
                  sq_x_in = 48'(ae) * 48'(ae) + 48'(ap) * 48'(ap);
                  sq_res_in = '0;
                  sq_bit_in = 48'd1 << 46;
                  state_in = ST_ROOT1;
               end else if (req_tlast) begin
                  state_in = ST_DIVSET;
               end
            end
         end
         ST_ROOT1, ST_ROOT2: begin
            if (sq_ge) sq_x_in = sq_x_ff - sq_sum;
            sq_res_in = root_out;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) state_in = (state_ff == ST_ROOT1) ? ST_THETA : ST_ACC1;
         end
         ST_THETA: begin
            // deltaR times inverse radius; the product is saturated and registered into theta below.
            mul_a = 32'(sq_res_ff);
            mul_b = 32'(inv_radius_ff);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            // The multiplier forms pt squared here while the second root is set up.
            sq_x_in = 48'(theta_ff) << ANGLE_FRAC_BITS;
            sq_res_in = '0;
            sq_bit_in = 48'd1 << 46;
            state_in = ST_ROOT2;
         end
         ST_ACC1: begin
            mul_a = 32'(pt_ff);
            mul_b = 32'(theta_ff);
            state_in = ST_ACC2;
         end
         ST_ACC2: begin
            mul_a = prod_ff[31:0];
            mul_b = 32'(theta_ff);
            state_in = last_ff ? ST_DIVSET : ST_IDLE;
         end
         ST_DIVSET: begin
            // The result registers are reused, so the previous response must be gone.
            if (!rsp_valid_ff) begin
               if (sum_pt_ff == '0) state_in = ST_OUT;
               else begin
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               if (div_idx_ff == 3'd3) state_in = ST_OUT;
               else state_in = ST_DIVSET;
            end
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inv_radius_ff <= 16'd10240;
         count_ff <= '0;
         sum_pt_ff <= '0;
         sum_pt2_ff <= '0;
         sum_root_ff <= '0;
         sum_ang_ff <= '0;
         sum_ang2_ff <= '0;
         rsp_valid_ff <= 1'b0;
         div_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) inv_radius_ff <= csr_wdata;
         if (state_ff == ST_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accepted) begin
                  pt_ff <= req_tdata[15:0];
                  last_ff <= req_tlast;
                  if (take) begin
                     count_ff <= count_ff + 8'd1;
                     sum_pt_ff <= sum_pt_ff + 24'(req_tdata[15:0]);
                  end
               end
            end
            ST_SQ: sum_pt2_ff <= sum_pt2_ff + 40'(mul_p[31:0]);
            ST_ACC1: begin
               sum_root_ff <= sum_root_ff + 40'(32'(pt_ff) * 32'(sq_res_ff[15:0]));
               sum_ang_ff <= sum_ang_ff + 44'(mul_p[31:0]);
            end
            ST_ACC2: sum_ang2_ff <= sum_ang2_ff + 56'(mul_p[47:0]);
            ST_DIV: begin
               if (!div_busy) begin
                  case (div_idx_ff)
                     3'd0: r_ptd_ff <= q_sat;
                     3'd1: r_lha_ff <= q_sat;
                     3'd2: r_wid_ff <= q_sat;
                     default: r_thr_ff <= q_sat;
                  endcase
                  div_idx_ff <= (div_idx_ff == 3'd3) ? 3'd0 : div_idx_ff + 3'd1;
               end
            end
            ST_OUT: begin
               r_zero_ff <= (sum_pt_ff == '0);
               r_mult_ff <= (sum_pt_ff == '0) ? 8'd0 : count_ff;
               if (sum_pt_ff == '0) begin
                  r_ptd_ff <= '0;
                  r_lha_ff <= '0;
                  r_wid_ff <= '0;
                  r_thr_ff <= '0;
               end
               count_ff <= '0;
               sum_pt_ff <= '0;
               sum_pt2_ff <= '0;
               sum_root_ff <= '0;
               sum_ang_ff <= '0;
               sum_ang2_ff <= '0;
            end
            default: ;
         endcase
      end
      sq_x_ff <= sq_x_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      prod_ff <= mul_p;
      // theta is held through the second root and the accumulation.
      if (state_ff == ST_THETA) begin
         theta_ff <= (mul_p[63:12] > 52'hFFFF) ? 16'hFFFF : mul_p[27:12];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {r_thr_ff, r_wid_ff, r_lha_ff, r_ptd_ff, r_mult_ff};
   assign rsp_tuser = r_zero_ff;
endmodule
